// ===== sv/disparity_to_depth_defines.svh =====
// Assertion macros used by the disparity-to-depth RTL.
`ifndef DISPARITY_TO_DEPTH_DEFINES_SVH
`define DISPARITY_TO_DEPTH_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define D2D_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define D2D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/d2d_pkg.sv =====
// Shared types and constants for the disparity-to-depth block.
package d2d_pkg;

    localparam int DISP_W           = 16;
    localparam int MIN_DISP_W       = 11;
    localparam int CFG_DATA_W       = 32;
    localparam int DEPTH_W          = 32;
    localparam int CFG_IDX_W        = 2;
    localparam int DISP_FRAC_BITS   = 4;
    localparam int DIV_BITS_PER_STG = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISPARITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_SCALE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_OFFSET  = 2'd2;

    // Per-stage control: stage holds an item, and that item has a positive divisor.
    typedef struct packed {
        logic vld;
        logic pos;
    } t_stg_ctl;

endpackage

// ===== sv/d2d_front.sv =====
// Input stage: forms the divisor and the shifted numerator for one item.
module d2d_front #(
    parameter int DISP_FRAC_BITS = d2d_pkg::DISP_FRAC_BITS,
    parameter int DEN_W          = 16,
    parameter int QUO_W          = 36
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [d2d_pkg::DISP_W-1:0]     i_disparity,
    input  logic signed [d2d_pkg::MIN_DISP_W-1:0] i_min_disp,
    input  logic        [d2d_pkg::CFG_DATA_W-1:0] i_scale,
    input  logic                                  i_ready_dn,
    output d2d_pkg::t_stg_ctl                     o_ctl,
    output logic        [DEN_W-1:0]               o_den,
    output logic        [QUO_W-1:0]               o_nq
);

    localparam int SUB_W = DEN_W + 1;

    d2d_pkg::t_stg_ctl        r_ctl;
    logic        [DEN_W-1:0]  r_den;
    logic        [QUO_W-1:0]  r_nq;
    logic signed [SUB_W-1:0]  s_diff;
    logic                     s_pos;

    assign o_ready = !r_ctl.vld || i_ready_dn;

    // Remainder after removing the minimum disparity, in sub-pixel units.
    always_comb begin
        s_diff = SUB_W'(i_disparity) - (SUB_W'(i_min_disp) <<< DISP_FRAC_BITS);
        s_pos  = !s_diff[SUB_W-1] && (s_diff != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (o_ready) begin
            r_ctl.vld <= i_valid;
            r_ctl.pos <= s_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_den <= s_diff[DEN_W-1:0];
            r_nq  <= QUO_W'(i_scale) << DISP_FRAC_BITS;
        end
    end

    assign o_ctl = r_ctl;
    assign o_den = r_den;
    assign o_nq  = r_nq;

endmodule

// ===== sv/d2d_div_stage.sv =====
// One pipeline stage of the restoring divider: STEPS quotient bits per stage.
module d2d_div_stage #(
    parameter int DEN_W = 16,
    parameter int QUO_W = 36,
    parameter int STEPS = d2d_pkg::DIV_BITS_PER_STG
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  d2d_pkg::t_stg_ctl i_ctl,
    output logic              o_ready,
    input  logic [DEN_W-1:0]  i_rem,
    input  logic [QUO_W-1:0]  i_nq,
    input  logic [DEN_W-1:0]  i_den,
    input  logic              i_ready_dn,
    output d2d_pkg::t_stg_ctl o_ctl,
    output logic [DEN_W-1:0]  o_rem,
    output logic [QUO_W-1:0]  o_nq,
    output logic [DEN_W-1:0]  o_den
);

    d2d_pkg::t_stg_ctl r_ctl;
    logic [DEN_W-1:0]  r_rem;
    logic [QUO_W-1:0]  r_nq;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  n_rem;
    logic [QUO_W-1:0]  n_nq;

    assign o_ready = !r_ctl.vld || i_ready_dn;

    // Shift in the next numerator bit, subtract the divisor where it fits.
    always_comb begin
        logic [DEN_W:0] v_trial;
        n_rem   = i_rem;
        n_nq    = i_nq;
        v_trial = '0;
        for (int i = 0; i < STEPS; i++) begin
            v_trial = {n_rem, n_nq[QUO_W-1]};
            n_nq    = n_nq << 1;
            if (v_trial >= {1'b0, i_den}) begin
                v_trial = v_trial - {1'b0, i_den};
                n_nq[0] = 1'b1;
            end
            n_rem = v_trial[DEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (o_ready) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_ctl.vld) begin
            r_rem <= n_rem;
            r_nq  <= n_nq;
            r_den <= i_den;
        end
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_nq  = r_nq;
    assign o_den = r_den;

endmodule

// ===== sv/d2d_back.sv =====
// Output: adds offset, saturates, zeroes invalid items, holds result.
module d2d_back #(
    parameter int QUO_W = 36
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  d2d_pkg::t_stg_ctl                     i_ctl,
    output logic                                  o_ready,
    input  logic        [QUO_W-1:0]               i_quot,
    input  logic signed [d2d_pkg::CFG_DATA_W-1:0] i_offset,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [d2d_pkg::DEPTH_W-1:0]    o_value,
    output logic                                  o_dvalid,
    output logic                                  o_sat
);

    localparam int SUM_W = QUO_W + 2;
    localparam int EXT_W = SUM_W - d2d_pkg::DEPTH_W;
    localparam logic signed [SUM_W-1:0] MAX_V =
        $signed({{EXT_W{1'b0}}, 1'b0, {(d2d_pkg::DEPTH_W-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] MIN_V =
        $signed({{EXT_W{1'b1}}, 1'b1, {(d2d_pkg::DEPTH_W-1){1'b0}}});

    logic                                r_vld;
    logic signed [d2d_pkg::DEPTH_W-1:0]  r_value;
    logic                                r_dvalid;
    logic                                r_sat;
    logic signed [SUM_W-1:0]             s_sum;
    logic signed [d2d_pkg::DEPTH_W-1:0]  n_value;
    logic                                n_sat;

    assign o_ready = !r_vld || !i_stall;

    always_comb begin
        s_sum   = $signed({2'b00, i_quot}) + SUM_W'(i_offset);
        n_sat   = 1'b0;
        n_value = s_sum[d2d_pkg::DEPTH_W-1:0];
        if (!i_ctl.pos) begin
            n_value = '0;
        end else if (s_sum > MAX_V) begin
            n_value = MAX_V[d2d_pkg::DEPTH_W-1:0];
            n_sat   = 1'b1;
        end else if (s_sum < MIN_V) begin
            n_value = MIN_V[d2d_pkg::DEPTH_W-1:0];
            n_sat   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_ctl.vld) begin
            r_value  <= n_value;
            r_dvalid <= i_ctl.pos;
            r_sat    <= n_sat;
        end
    end

    assign o_valid  = r_vld;
    assign o_value  = r_value;
    assign o_dvalid = r_dvalid;
    assign o_sat    = r_sat;

endmodule

// ===== sv/disparity_to_depth.sv =====
// Top level: stereo disparity to depth conversion, one item per clock while no stall
// holds the pipeline. Each item passes through the registered front stage, divider
// stages and output stage; a stage takes a new item as its last one moves on.
// The divider pipeline retires 4 quotient bits per stage.
// Synchronous active-low reset clears every stage valid bit and loads register defaults.
`include "disparity_to_depth_defines.svh"

module disparity_to_depth #(
    parameter int DISP_FRAC_BITS = d2d_pkg::DISP_FRAC_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_wr_en,
    input  logic        [d2d_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [d2d_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input item channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [d2d_pkg::DISP_W-1:0]     i_disparity_sixteenths,
    // result item channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [d2d_pkg::DEPTH_W-1:0]    o_depth_value,
    output logic                                  o_depth_valid,
    output logic                                  o_depth_saturated
);

    // Divisor width: the largest positive remainder of disparity minus the
    // scaled minimum fits in this many unsigned bits.
    localparam int MIN_SH_W = d2d_pkg::MIN_DISP_W + DISP_FRAC_BITS;
    localparam int DEN_W    = (MIN_SH_W > d2d_pkg::DISP_W) ? MIN_SH_W : d2d_pkg::DISP_W;
    // Numerator is the scale shifted up by the disparity fraction bits.
    localparam int QUO_W    = d2d_pkg::CFG_DATA_W + DISP_FRAC_BITS;
    localparam int BPS      = d2d_pkg::DIV_BITS_PER_STG;
    localparam int NDIV     = (QUO_W + BPS - 1) / BPS;
    localparam int LAST_STP = QUO_W - BPS * (NDIV - 1);

    // ------------------------------------------------------------------
    // Configuration registers. Written only while the pipeline is empty (the user's
    // duty; the block does not enforce it), so each stage reads them directly.
    // ------------------------------------------------------------------
    logic signed [d2d_pkg::MIN_DISP_W-1:0] r_min_disp;
    logic        [d2d_pkg::CFG_DATA_W-1:0] r_depth_scale;
    logic signed [d2d_pkg::CFG_DATA_W-1:0] r_depth_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_disp     <= '0;
            r_depth_scale  <= d2d_pkg::CFG_DATA_W'(65536);
            r_depth_offset <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                d2d_pkg::CFG_MIN_DISPARITY: begin
                    r_min_disp <= i_cfg_data[d2d_pkg::MIN_DISP_W-1:0];
                end
                d2d_pkg::CFG_DEPTH_SCALE: begin
                    r_depth_scale <= i_cfg_data;
                end
                d2d_pkg::CFG_DEPTH_OFFSET: begin
                    r_depth_offset <= i_cfg_data;
                end
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline boundaries. Boundary 0 is the front stage output, boundary
    // NDIV feeds the output stage. s_rdy[k] is the ready of whoever
    // consumes boundary k; each stage advances when it is empty or its
    // consumer advances, so bubbles collapse under an output stall.
    // ------------------------------------------------------------------
    d2d_pkg::t_stg_ctl  s_ctl [NDIV+1];
    logic [DEN_W-1:0]   s_rem [NDIV+1];
    logic [QUO_W-1:0]   s_nq  [NDIV+1];
    logic [DEN_W-1:0]   s_den [NDIV+1];
    logic               s_rdy [NDIV+1];
    logic               s_front_rdy;

    // The partial remainder starts at zero for every item.
    assign s_rem[0] = '0;

    d2d_front #(
        .DISP_FRAC_BITS (DISP_FRAC_BITS),
        .DEN_W          (DEN_W),
        .QUO_W          (QUO_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (s_front_rdy),
        .i_disparity (i_disparity_sixteenths),
        .i_min_disp  (r_min_disp),
        .i_scale     (r_depth_scale),
        .i_ready_dn  (s_rdy[0]),
        .o_ctl       (s_ctl[0]),
        .o_den       (s_den[0]),
        .o_nq        (s_nq[0])
    );

    // Stall the input only when the front stage is full and cannot drain.
    assign o_in_stall = !s_front_rdy;

    // Divider stages: each retires BPS quotient bits, the last one the rest.
    for (genvar gk = 0; gk < NDIV; gk++) begin : g_div
        d2d_div_stage #(
            .DEN_W (DEN_W),
            .QUO_W (QUO_W),
            .STEPS ((gk == NDIV - 1) ? LAST_STP : BPS)
        ) u_stage (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (s_ctl[gk]),
            .o_ready    (s_rdy[gk]),
            .i_rem      (s_rem[gk]),
            .i_nq       (s_nq[gk]),
            .i_den      (s_den[gk]),
            .i_ready_dn (s_rdy[gk+1]),
            .o_ctl      (s_ctl[gk+1]),
            .o_rem      (s_rem[gk+1]),
            .o_nq       (s_nq[gk+1]),
            .o_den      (s_den[gk+1])
        );
    end

    // Output stage: offset add, saturation, and the result register that
    // holds an item while the consumer stalls.
    d2d_back #(
        .QUO_W (QUO_W)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (s_ctl[NDIV]),
        .o_ready  (s_rdy[NDIV]),
        .i_quot   (s_nq[NDIV]),
        .i_offset (r_depth_offset),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_value  (o_depth_value),
        .o_dvalid (o_depth_valid),
        .o_sat    (o_depth_saturated)
    );

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `D2D_ASSERT_IMPLY(a_invalid_zero, o_out_valid && !o_depth_valid, (o_depth_value == '0) && !o_depth_saturated, "invalid item must carry zero depth and no saturation")
    `D2D_ASSERT_IMPLY(a_sat_clip, o_out_valid && o_depth_saturated, (o_depth_value == 32'sh7FFF_FFFF) || (o_depth_value == 32'sh8000_0000), "saturated depth must sit at a range limit")
    `D2D_ASSERT_IMPLY(a_stall_full, o_in_stall, o_out_valid && i_out_stall, "input stalled while output side is free")
    `D2D_ASSERT_NEXT(a_stall_keeps, o_in_stall, o_out_valid, "full pipeline lost its output item")
    `D2D_ASSERT_IMPLY(a_quot_nonneg, o_out_valid && o_depth_valid && !o_depth_saturated && (r_depth_offset == '0), !o_depth_value[d2d_pkg::DEPTH_W-1], "depth with zero offset must not be negative")

endmodule

// ===== sim/tb_disparity_to_depth.sv =====
// Self-checking testbench for the disparity-to-depth converter.
module tb_disparity_to_depth;
    timeunit 1ns;
    timeprecision 1ps;

    // Pipeline depth: the front and output stages plus one divider stage
    // per four quotient bits.
    localparam int LATENCY       = 2 + (d2d_pkg::DEPTH_W + d2d_pkg::DISP_FRAC_BITS + 3) / 4;
    localparam int HOLD_CYCLES   = 120;   // long receiver hold-off
    localparam int RANDOM_PHASES = 8;

    // Index past the last register; the block must ignore writes to it.
    localparam logic [d2d_pkg::CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    localparam longint DEPTH_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint DEPTH_MIN = -64'sh0000_0000_8000_0000;

    typedef struct packed {
        logic signed [d2d_pkg::DEPTH_W-1:0] value;
        logic                               valid;
        logic                               saturated;
    } t_depth_result;

    // Receiver stall patterns.
    typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_HEAVY} t_rx_mode;

    // Predicts each depth result and checks the block's results in order.
    class depth_predictor;
        logic signed [d2d_pkg::MIN_DISP_W-1:0] min_disp;
        logic        [d2d_pkg::CFG_DATA_W-1:0] scale;
        logic signed [d2d_pkg::DEPTH_W-1:0]    offset;
        t_depth_result                         pending_depths[$];
        int                                    errors;

        function new();
            min_disp = '0;
            scale    = 32'd65536;
            offset   = '0;
            errors   = 0;
        endfunction

        function void write_reg(logic [d2d_pkg::CFG_IDX_W-1:0] idx,
                                logic [d2d_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                d2d_pkg::CFG_MIN_DISPARITY: min_disp = data[d2d_pkg::MIN_DISP_W-1:0];
                d2d_pkg::CFG_DEPTH_SCALE:   scale    = data;
                d2d_pkg::CFG_DEPTH_OFFSET:  offset   = data;
                default: ;   // unused index: drop the write
            endcase
        endfunction

        function t_depth_result compute_depth(logic signed [d2d_pkg::DISP_W-1:0] disp);
            longint          denom;
            longint          quot;
            longint          sum;
            longint unsigned numer;
            t_depth_result   r;
            r = '0;
            // Bring the whole-pixel minimum to sixteenths and subtract.
            denom = longint'(disp) - (longint'(min_disp) <<< d2d_pkg::DISP_FRAC_BITS);
            if (denom <= 0)
                return r;
            // Fraction bits cancel; the quotient is truncated toward zero.
            numer = {32'd0, scale} << d2d_pkg::DISP_FRAC_BITS;
            quot  = longint'(numer / longint'(denom));
            sum   = quot + longint'(offset);
            r.valid = 1'b1;
            if (sum > DEPTH_MAX) begin
                sum         = DEPTH_MAX;
                r.saturated = 1'b1;
            end else if (sum < DEPTH_MIN) begin
                sum         = DEPTH_MIN;
                r.saturated = 1'b1;
            end
            r.value = sum[d2d_pkg::DEPTH_W-1:0];
            return r;
        endfunction

        function void note_disparity(logic signed [d2d_pkg::DISP_W-1:0] disp);
            pending_depths.insert(pending_depths.size(), compute_depth(disp));
        endfunction

        function void report(string field, longint want, longint got);
            $display("[%0t] %s: expected %0d, actual %0d", $time, field, want, got);
            errors++;
        endfunction

        function void check_depth(logic signed [d2d_pkg::DEPTH_W-1:0] value, logic valid,
                                  logic sat);
            t_depth_result want;
            if (pending_depths.size() == 0) begin
                $display("[%0t] result with no pending item: expected none, actual %0d %b %b",
                         $time, value, valid, sat);
                errors++;
                return;
            end
            want = pending_depths.pop_front();
            if (value !== want.value)
                report("depth_value", want.value, value);
            if (valid !== want.valid)
                report("depth_valid", want.valid, valid);
            if (sat !== want.saturated)
                report("depth_saturated", want.saturated, sat);
        endfunction
    endclass

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n;
    logic                                  i_cfg_wr_en;
    logic [d2d_pkg::CFG_IDX_W-1:0]         i_cfg_index;
    logic [d2d_pkg::CFG_DATA_W-1:0]        i_cfg_data;
    logic                                  i_in_valid;
    logic                                  o_in_stall;
    logic signed [d2d_pkg::DISP_W-1:0]     i_disparity_sixteenths;
    logic                                  o_out_valid;
    logic                                  i_out_stall = 1'b0;
    logic signed [d2d_pkg::DEPTH_W-1:0]    o_depth_value;
    logic                                  o_depth_valid;
    logic                                  o_depth_saturated;

    depth_predictor predictor = new();

    // Sender pacing: bursts of items separated by idle gaps.
    bit sender_bursty;
    int burst_left;

    // Hold-off requests from the stimulus; the receiver serves each one.
    int hold_requests = 0;

    disparity_to_depth dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_wr_en            (i_cfg_wr_en),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data),
        .i_in_valid             (i_in_valid),
        .o_in_stall             (o_in_stall),
        .i_disparity_sixteenths (i_disparity_sixteenths),
        .o_out_valid            (o_out_valid),
        .i_out_stall            (i_out_stall),
        .o_depth_value          (o_depth_value),
        .o_depth_valid          (o_depth_valid),
        .o_depth_saturated      (o_depth_saturated)
    );

    always #5 i_clk = ~i_clk;

    // Offer one item and hold it until accepted. Enter and leave at a falling edge.
    task automatic send_disparity(input logic signed [d2d_pkg::DISP_W-1:0] disp);
        int gap;
        if (sender_bursty) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 24);
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left--;
        end
        i_in_valid             = 1'b1;
        i_disparity_sixteenths = disp;
        do @(posedge i_clk); while (o_in_stall);
        predictor.note_disparity(disp);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic drain_results();
        i_in_valid = 1'b0;
        while (predictor.pending_depths.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Register write; only called with the pipeline drained.
    task automatic write_reg(input logic [d2d_pkg::CFG_IDX_W-1:0] idx,
                             input logic [d2d_pkg::CFG_DATA_W-1:0] data);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        predictor.write_reg(idx, data);
    endtask

    // Half the samples land near the threshold so that valid and invalid results
    // mix; some force tiny divisors (large quotients, saturation); the rest
    // cover the full 16-bit range.
    function automatic logic signed [d2d_pkg::DISP_W-1:0] pick_disparity(
        logic signed [d2d_pkg::MIN_DISP_W-1:0] min_disp
    );
        int base;
        int delta;
        int v;
        base = int'(min_disp) * (1 << d2d_pkg::DISP_FRAC_BITS);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: delta = int'($urandom_range(0, 400)) - 64;
            5, 6:          delta = int'($urandom_range(1, 40));
            default: begin
                v = $urandom();
                return v[d2d_pkg::DISP_W-1:0];
            end
        endcase
        v = base + delta;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[d2d_pkg::DISP_W-1:0];
    endfunction

    // Receiver: change stall pattern every so often; serve long hold-offs.
    always @(negedge i_clk) begin : receiver
        static t_rx_mode rx_mode    = RX_FREE;
        static int       mode_left  = 0;
        static int       hold_left  = 0;
        static int       hold_done  = 0;
        static int       phase_cnt  = 0;
        logic            stall;
        if (hold_done != hold_requests) begin
            hold_done = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            stall = 1'b1;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            phase_cnt++;
            case (rx_mode)
                RX_FREE:     stall = 1'b0;
                RX_RANDOM:   stall = ($urandom_range(0, 99) < 30);
                RX_PERIODIC: stall = ((phase_cnt % 7) >= 5);
                default:     stall = ($urandom_range(0, 99) < 75);
            endcase
        end
        i_out_stall <= stall;
    end

    // Check every accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            predictor.check_depth(o_depth_value, o_depth_valid, o_depth_saturated);
    end

    initial begin : stimulus
        int                                    phase;
        int                                    n_items;
        int                                    k;
        logic [d2d_pkg::CFG_DATA_W-1:0]        data;
        logic signed [d2d_pkg::MIN_DISP_W-1:0] min_disp;

        i_rst_n                = 1'b0;
        i_cfg_wr_en            = 1'b0;
        i_cfg_index            = d2d_pkg::CFG_MIN_DISPARITY;
        i_cfg_data             = '0;
        i_in_valid             = 1'b0;
        i_disparity_sixteenths = '0;
        sender_bursty          = 1'b0;
        burst_left             = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: zero and negative remainders are invalid, a remainder
        // of one sixteenth gives the largest quotient, three truncates.
        send_disparity(16'sd0);
        send_disparity(16'sd1);
        send_disparity(-16'sd1);
        send_disparity(16'sd16);
        send_disparity(16'sd3);
        send_disparity(16'sd32767);
        send_disparity(-16'sd32768);
        drain_results();

        // A write past the last register must leave the settings unchanged.
        write_reg(CFG_UNUSED_INDEX, 32'hFFFF_FFFF);
        send_disparity(16'sd1);
        drain_results();

        // Most negative minimum, full scale, largest offset: saturate high.
        write_reg(d2d_pkg::CFG_MIN_DISPARITY, 32'h0000_0400);
        write_reg(d2d_pkg::CFG_DEPTH_SCALE, 32'hFFFF_FFFF);
        write_reg(d2d_pkg::CFG_DEPTH_OFFSET, 32'h7FFF_FFFF);
        send_disparity(-16'sd32768);
        send_disparity(-16'sd16384);
        send_disparity(-16'sd16383);
        send_disparity(16'sd32767);
        drain_results();

        // Largest minimum, most negative offset.
        write_reg(d2d_pkg::CFG_MIN_DISPARITY, 32'h0000_03FF);
        write_reg(d2d_pkg::CFG_DEPTH_OFFSET, 32'h8000_0000);
        send_disparity(16'sd32767);
        send_disparity(16'sd16368);
        send_disparity(16'sd16369);
        send_disparity(-16'sd32768);
        drain_results();

        // Minimum outside the nominal range with junk in the upper data bits,
        // zero scale: the offset alone lands exactly on the top of the range.
        write_reg(d2d_pkg::CFG_MIN_DISPARITY, 32'hFFFF_F800 | 32'd600);
        write_reg(d2d_pkg::CFG_DEPTH_SCALE, 32'h0000_0000);
        write_reg(d2d_pkg::CFG_DEPTH_OFFSET, 32'h7FFF_FFFF);
        send_disparity(16'sd9600);
        send_disparity(16'sd9601);
        send_disparity(16'sd32767);

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_results();

            case ($urandom_range(0, 4))
                0:       data = 32'h0000_0400;
                1:       data = 32'h0000_03FF;
                2:       data = int'($urandom_range(0, 1024)) - 512;
                3:       data = $urandom();
                default: data = '0;
            endcase
            min_disp = data[d2d_pkg::MIN_DISP_W-1:0];
            data = $urandom();
            data[d2d_pkg::MIN_DISP_W-1:0] = min_disp;
            write_reg(d2d_pkg::CFG_MIN_DISPARITY, data);

            case ($urandom_range(0, 4))
                0:       data = 32'h0000_0000;
                1:       data = 32'hFFFF_FFFF;
                2:       data = $urandom();
                3:       data = $urandom_range(0, 1 << 20);
                default: data = 32'd65536 * $urandom_range(1, 200);
            endcase
            write_reg(d2d_pkg::CFG_DEPTH_SCALE, data);

            case ($urandom_range(0, 4))
                0:       data = 32'h8000_0000;
                1:       data = 32'h7FFF_FFFF;
                2:       data = $urandom();
                3:       data = 32'h0000_0000;
                default: data = int'($urandom_range(0, 1 << 22)) - (1 << 21);
            endcase
            write_reg(d2d_pkg::CFG_DEPTH_OFFSET, data);

            // Every third phase runs without sender gaps.
            sender_bursty = (phase % 3 != 0);
            burst_left    = 0;

            // Hold off the receiver and keep offering items back to back so
            // the pipeline fills and stalls its input.
            if (phase == 1) begin
                sender_bursty = 1'b0;
                hold_requests++;
                repeat (80) send_disparity(pick_disparity(predictor.min_disp));
                sender_bursty = 1'b1;
            end

            n_items = $urandom_range(90, 120);
            for (k = 0; k < n_items; k++) begin
                // Pause midway until every pending result is out.
                if (phase == 3 && k == n_items / 2)
                    drain_results();
                send_disparity(pick_disparity(predictor.min_disp));
            end
        end

        drain_results();
        repeat (2 * LATENCY) @(posedge i_clk);
        if (predictor.errors == 0 && predictor.pending_depths.size() == 0)
            $display("disparity_to_depth: match");
        else
            $display("disparity_to_depth: mismatch");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #3ms;
        $display("disparity_to_depth: mismatch");
        $finish;
    end

endmodule

// ===== disparity_to_depth.f =====
+incdir+sv
sv/d2d_pkg.sv
sv/d2d_front.sv
sv/d2d_div_stage.sv
sv/d2d_back.sv
sv/disparity_to_depth.sv
sim/tb_disparity_to_depth.sv
